// ----- src/assert_macros.svh -----
// Assertion helpers included by the top-level core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/rfifo_pkg.sv -----
package rfifo_pkg;

  localparam int ITEM_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_RDNEW  = 3'd3,
    OP_UPDNEW = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [ITEM_W-1:0]  item_data;
    logic [INDEX_W-1:0] index;
  } request_t;

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  read_data;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;
  } result_t;

  typedef struct packed {
    logic exec;
    logic cfg_we;
  } cmd_t;

endpackage

// ----- src/rfifo_ram.sv -----
module rfifo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rfifo_ctrl.sv -----
module rfifo_ctrl import rfifo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic cfg_valid,
  output logic busy,
  output logic out_valid,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_RESP);
  assign cmd.exec   = start && (state_r == ST_IDLE);
  assign cmd.cfg_we = cfg_valid;

endmodule

// ----- src/rfifo_dp.sv -----
module rfifo_dp import rfifo_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     cmd,
  input  logic     cfg_data,
  input  request_t req,
  output result_t  res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int AW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
  localparam int SW = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;

  logic [PW-1:0] newest_r, newest_nxt;
  logic [PW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ow_r;
  logic          ok_r, ok_nxt;
  logic          rdsel_r, rdsel_nxt;

  logic          full, empty, peek_ok;
  logic [AW-1:0] peek_sum, peek_wrap;
  logic [PW-1:0] newest_inc, oldest_inc;
  logic [PW-1:0] addr;
  logic          ram_we, ram_re;
  logic [SW-1:0] rdata;
  logic [XW:0]   cnt_x;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full       = (cnt_r == CW'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign newest_inc = wrap_inc(newest_r);
  assign oldest_inc = wrap_inc(oldest_r);
  assign peek_ok    = !empty && (XW'(req.index) < XW'(cnt_r));
  assign peek_sum   = AW'(oldest_r) + AW'(req.index);
  assign peek_wrap  = (peek_sum >= AW'(DEPTH)) ? peek_sum - AW'(DEPTH) : peek_sum;

  always_comb begin
    newest_nxt = newest_r;
    oldest_nxt = oldest_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = 1'b0;
    rdsel_nxt  = 1'b0;
    addr       = newest_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (req.opcode)
      OP_PUSH: begin
        if (!full || ow_r) begin
          ok_nxt = 1'b1;
          ram_we = 1'b1;
          if (!empty) begin
            newest_nxt = newest_inc;
            addr       = newest_inc;
          end
          if (full) begin
            oldest_nxt = oldest_inc;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      OP_POP: begin
        addr = oldest_r;
        if (!empty) begin
          ok_nxt    = 1'b1;
          rdsel_nxt = 1'b1;
          ram_re    = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            newest_nxt = '0;
            oldest_nxt = '0;
          end else begin
            oldest_nxt = oldest_inc;
          end
        end
      end
      OP_PEEK: begin
        addr = peek_wrap[PW-1:0];
        if (peek_ok) begin
          ok_nxt    = 1'b1;
          rdsel_nxt = 1'b1;
          ram_re    = 1'b1;
        end
      end
      OP_RDNEW: begin
        if (!empty) begin
          ok_nxt    = 1'b1;
          rdsel_nxt = 1'b1;
          ram_re    = 1'b1;
        end
      end
      OP_UPDNEW: begin
        if (!empty) begin
          ok_nxt = 1'b1;
          ram_we = 1'b1;
        end
      end
      OP_CLEAR: begin
        ok_nxt     = 1'b1;
        newest_nxt = '0;
        oldest_nxt = '0;
        cnt_nxt    = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      oldest_r <= '0;
      cnt_r    <= '0;
      ow_r     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        newest_r <= newest_nxt;
        oldest_r <= oldest_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (cmd.cfg_we) begin
        ow_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r    <= ok_nxt;
      rdsel_r <= rdsel_nxt;
    end
  end

  rfifo_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.exec && ram_we),
    .re   (cmd.exec && ram_re),
    .addr (addr),
    .wdata(req.item_data[SW-1:0]),
    .rdata(rdata)
  );

  assign cnt_x         = (XW + 1)'(cnt_r);
  assign res.ok        = ok_r;
  assign res.read_data = rdsel_r ? ITEM_W'(rdata) : '0;
  assign res.count     = cnt_x[COUNT_W-1:0];
  assign res.empty_res = empty;
  assign res.full_res  = full;

endmodule

// ----- src/ring_fifo_with_overwrite_core.sv -----
// Channel   Ports                           Transfer when
// --------  ------------------------------  ---------------------------
// request   start, busy, in_req             start && !busy
// result    out_valid, out_res              out_valid (one cycle)
// config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// Each operation does the store access in the accept cycle and gives the
// result in the next cycle, set by the registered read of the item RAM.
// busy is high in the result cycle; a new request is taken the cycle after.
// Synchronous active-low reset empties the FIFO and clears overwrite mode.
// The result strobe lasts one cycle and cannot be stalled.
`include "assert_macros.svh"

module ring_fifo_with_overwrite_core import rfifo_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  request_t in_req,
  output logic     out_valid,
  output result_t  out_res,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  cmd_t cmd;

  rfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg_valid(cfg_valid),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  rfifo_dp #(
    .DEPTH    (DEPTH),
    .ITEM_BITS(ITEM_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cfg_data(cfg_data),
    .req     (in_req),
    .res     (out_res)
  );

  assign cfg_ready = 1'b1;

  `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, start && !busy, out_valid)
  `ASSERT_SAME(a_result_while_busy, clk, rst_n, out_valid, busy)
  `ASSERT_SAME(a_refused_reads_zero, clk, rst_n, out_valid && !out_res.ok,
               out_res.read_data == '0)
  `ASSERT_SAME(a_empty_zero_count, clk, rst_n, out_valid && out_res.empty_res,
               out_res.count == '0 && !out_res.full_res)

endmodule

// ----- verif/ring_fifo_with_overwrite_core_tb.sv -----
`timescale 1ns / 1ps

module ring_fifo_with_overwrite_core_tb;
  import rfifo_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  request_t in_req = '0;
  logic     out_valid;
  result_t  out_res;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  // predicted fifo state
  logic [ITEM_W-1:0]  mdl_store [FIFO_DEPTH];
  logic [INDEX_W-1:0] mdl_newest = '0;
  logic [INDEX_W-1:0] mdl_oldest = '0;
  logic [COUNT_W-1:0] mdl_count = '0;
  logic               mdl_overwrite = 1'b0;

  result_t pending_results [$];
  int      mismatches = 0;
  bit      gaps_on = 1'b1;

  ring_fifo_with_overwrite_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic result_t fifo_apply(request_t r);
    result_t            res;
    logic               full;
    logic [INDEX_W-1:0] slot;
    res = '0;
    full = (mdl_count == FIFO_DEPTH);
    case (r.opcode)
      OP_PUSH: begin
        if (!full || mdl_overwrite) begin
          if (mdl_count != 0) mdl_newest = mdl_newest + 1'b1;
          mdl_store[mdl_newest] = r.item_data;
          if (full) mdl_oldest = mdl_oldest + 1'b1;
          else mdl_count = mdl_count + 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (mdl_count != 0) begin
          res.read_data = mdl_store[mdl_oldest];
          mdl_count = mdl_count - 1'b1;
          if (mdl_count == 0) begin
            mdl_newest = '0;
            mdl_oldest = '0;
          end else begin
            mdl_oldest = mdl_oldest + 1'b1;
          end
          res.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        if (mdl_count != 0 && r.index < mdl_count) begin
          slot = mdl_oldest + r.index;
          res.read_data = mdl_store[slot];
          res.ok = 1'b1;
        end
      end
      OP_RDNEW: begin
        if (mdl_count != 0) begin
          res.read_data = mdl_store[mdl_newest];
          res.ok = 1'b1;
        end
      end
      OP_UPDNEW: begin
        if (mdl_count != 0) begin
          mdl_store[mdl_newest] = r.item_data;
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        mdl_newest = '0;
        mdl_oldest = '0;
        mdl_count = '0;
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.count = mdl_count;
    res.empty_res = (mdl_count == 0);
    res.full_res = (mdl_count == FIFO_DEPTH);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result ok=%0d rd=%h cnt=%0d empty=%0d full=%0d",
                   $realtime, out_res.ok, out_res.read_data, out_res.count,
                   out_res.empty_res, out_res.full_res);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res.ok !== exp_res.ok || out_res.read_data !== exp_res.read_data ||
            out_res.count !== exp_res.count || out_res.empty_res !== exp_res.empty_res ||
            out_res.full_res !== exp_res.full_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp ok=%0d rd=%h cnt=%0d e=%0d f=%0d",
                      " got ok=%0d rd=%h cnt=%0d e=%0d f=%0d"},
                     $realtime, exp_res.ok, exp_res.read_data, exp_res.count,
                     exp_res.empty_res, exp_res.full_res, out_res.ok, out_res.read_data,
                     out_res.count, out_res.empty_res, out_res.full_res);
        end
      end
    end
  end

  task automatic issue_op(input logic [2:0] op, input logic [ITEM_W-1:0] data,
                          input logic [INDEX_W-1:0] idx);
    request_t r;
    r.opcode = op;
    r.item_data = data;
    r.index = idx;
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(fifo_apply(r));
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 99) < 15) hold_off($urandom_range(1, 18));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_overwrite(input logic value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mdl_overwrite = value;
  endtask

  task automatic test_empty_ops();
    set_overwrite(1'b0);
    issue_op(OP_POP, '0, '0);
    issue_op(OP_PEEK, '0, '0);
    issue_op(OP_RDNEW, '0, '0);
    issue_op(OP_UPDNEW, '1, '0);
  endtask

  task automatic test_push_read_update();
    issue_op(OP_PUSH, '0, '0);
    issue_op(OP_RDNEW, '0, '0);
    issue_op(OP_UPDNEW, '1, '0);
    hold_off(3);
    issue_op(OP_RDNEW, '0, '0);
    issue_op(OP_PEEK, '0, '0);
    issue_op(OP_PEEK, '0, 4'd1);
    issue_op(OP_POP, '0, '0);
    issue_op(OP_PUSH, 32'ha5a5a5a5, '0);
    issue_op(OP_PUSH, 32'h5a5a5a5a, '1);
    issue_op(OP_PEEK, '0, 4'd1);
    issue_op(OP_POP, '0, '0);
    issue_op(OP_POP, '0, '0);
  endtask

  task automatic test_fill_and_overwrite();
    for (int i = 0; i < FIFO_DEPTH; i++) issue_op(OP_PUSH, $urandom, '0);
    issue_op(OP_PUSH, '1, '0);
    set_overwrite(1'b1);
    issue_op(OP_PUSH, 32'hdeadbeef, '0);
    issue_op(OP_PEEK, '0, '1);
    issue_op(OP_RDNEW, '0, '0);
    issue_op(OP_CLEAR, '0, '0);
  endtask

  task automatic test_illegal_ops();
    issue_op(OP_PUSH, 32'h12345678, '0);
    issue_op(OP_BAD_LO, '1, '1);
    issue_op(OP_BAD_HI, '1, '1);
    issue_op(OP_RDNEW, '0, '0);
  endtask

  task automatic random_burst(input int items, input int push_pct, input int pause_at);
    logic [2:0]         op;
    logic [INDEX_W-1:0] idx;
    int                 pick;
    for (int n = 0; n < items; n++) begin
      if (n == pause_at) drain();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
      else if (pick < 40) op = OP_POP;
      else if (pick < 65) op = OP_PEEK;
      else if (pick < 77) op = OP_RDNEW;
      else if (pick < 89) op = OP_UPDNEW;
      else if (pick < 94) op = OP_CLEAR;
      else op = pick[0] ? OP_BAD_HI : OP_BAD_LO;
      if (mdl_count != 0 && $urandom_range(0, 99) < 70)
        idx = INDEX_W'($urandom_range(0, mdl_count - 1));
      else
        idx = INDEX_W'($urandom_range(0, 15));
      issue_op(op, $urandom, idx);
      maybe_gap();
    end
  endtask

  task automatic test_random_traffic();
    set_overwrite(1'b0);
    random_burst(200, 50, -1);
    set_overwrite(1'b1);
    random_burst(200, 65, 100);
    set_overwrite(1'b0);
    random_burst(150, 60, -1);
    set_overwrite(1'b1);
    gaps_on = 1'b0;
    random_burst(150, 45, -1);
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_ops();
    test_push_read_update();
    test_fill_and_overwrite();
    test_illegal_ops();
    test_random_traffic();
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ring_fifo_with_overwrite_core test passed");
    end else begin
      $display("ring_fifo_with_overwrite_core test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("ring_fifo_with_overwrite_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/rfifo_pkg.sv
src/rfifo_ram.sv
src/rfifo_ctrl.sv
src/rfifo_dp.sv
src/ring_fifo_with_overwrite_core.sv
verif/ring_fifo_with_overwrite_core_tb.sv
